### design/u2a_pkg.sv
// shared types, constants and the digit-to-ascii function for the digit converter
package u2a_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 7;
  localparam int POS_W      = 4;
  localparam int IDX_W      = 4;
  localparam int DIGIT_W    = 4;
  localparam int DEC_DIGITS = 10;
  localparam int HEX_DIGITS = 8;
  localparam int WIDE_W     = 36;

  localparam logic [1:0] OP_DEC       = 2'd0;
  localparam logic [1:0] OP_HEX_UPPER = 2'd1;
  localparam logic [1:0] OP_HEX_LOWER = 2'd2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;

  localparam logic [WIDE_W-1:0] POW10 [DEC_DIGITS] = '{
    36'd1, 36'd10, 36'd100, 36'd1000, 36'd10000, 36'd100000,
    36'd1000000, 36'd10000000, 36'd100000000, 36'd1000000000
  };

  typedef enum logic {ST_IDLE, ST_EMIT} state_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               hex;
    logic               upper;
    logic [IDX_W-1:0]   top;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_rd_t;

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? ASCII_UPPER_A : ASCII_LOWER_A;
    if (d < 4'd10) begin
      return ASCII_ZERO + CHAR_W'(d);
    end
    return base + CHAR_W'(d - 4'd10);
  endfunction

endpackage

### design/u2a_front.sv
// front end: accepts a beat, picks the radix and finds the top digit index
module u2a_front (
  input  logic                        valid,
  output logic                        stall,
  input  logic [u2a_pkg::VALUE_W-1:0] value,
  input  logic [1:0]                  opcode,
  input  logic                        full,
  output u2a_pkg::q_wr_t              wr
);
  import u2a_pkg::*;

  logic [IDX_W-1:0] dec_top;
  logic [IDX_W-1:0] hex_top;
  logic             hex;

  assign hex   = opcode inside {OP_HEX_UPPER, OP_HEX_LOWER};
  assign stall = full;

  // thresholds are monotonic, so the highest one passed gives the top digit index
  always_comb begin
    dec_top = '0;
    for (int k = 1; k < DEC_DIGITS; k++) begin
      if ({4'b0000, value} >= POW10[k]) begin
        dec_top = IDX_W'(k);
      end
    end
  end

  always_comb begin
    hex_top = '0;
    for (int k = 1; k < HEX_DIGITS; k++) begin
      if (value[4*k +: 4] != 4'd0) begin
        hex_top = IDX_W'(k);
      end
    end
  end

  always_comb begin
    wr.push      = valid && !full;
    wr.job.value = value;
    wr.job.hex   = hex;
    wr.job.upper = (opcode == OP_HEX_UPPER);
    wr.job.top   = hex ? hex_top : dec_top;
  end

endmodule

### design/u2a_queue.sv
// short job queue between the front end and the digit sequencer
module u2a_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  u2a_pkg::q_wr_t wr,
  input  logic           pop,
  output logic           full,
  output u2a_pkg::q_rd_t rd
);
  import u2a_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && (count != '0);
  assign rd.valid = (count != '0);
  assign rd.job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr.job;
    end
  end

endmodule

### design/u2a_back.sv
// back end: walks the digits most significant first, one per cycle unless the output stalls, into the output register
module u2a_back (
  input  logic                        clk,
  input  logic                        rst,
  input  u2a_pkg::q_rd_t              rd,
  output logic                        pop,
  output logic                        valid,
  input  logic                        stall,
  output logic [u2a_pkg::CHAR_W-1:0]  char_code,
  output logic [u2a_pkg::POS_W-1:0]   position,
  output logic                        last
);
  import u2a_pkg::*;

  state_t             state;
  state_t             state_next;
  logic               adv;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] rem_next;
  logic               hex;
  logic               upper;
  logic [IDX_W-1:0]   idx;
  logic [POS_W-1:0]   pos;
  logic [WIDE_W-1:0]  thr [DEC_DIGITS];
  logic [DIGIT_W-1:0] dec_dig;
  logic [DIGIT_W-1:0] hex_dig;
  logic [DIGIT_W-1:0] dig;

  // multiples of the current power of ten, compared side by side
  always_comb begin
    thr[0] = '0;
    for (int d = 1; d < DEC_DIGITS; d++) begin
      thr[d] = POW10[idx] * WIDE_W'(d);
    end
  end

  always_comb begin
    dec_dig = '0;
    for (int d = 1; d < DEC_DIGITS; d++) begin
      if ({4'b0000, rem} >= thr[d]) begin
        dec_dig = DIGIT_W'(d);
      end
    end
  end

  assign hex_dig  = DIGIT_W'(rem >> {idx[2:0], 2'b00});
  assign dig      = hex ? hex_dig : dec_dig;
  assign rem_next = rem - thr[dec_dig][VALUE_W-1:0];

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    adv        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (rd.valid) begin
          pop        = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!valid || !stall) begin
          adv = 1'b1;
          if (idx == '0) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        valid <= 1'b1;
      end else if (!stall) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem   <= rd.job.value;
      hex   <= rd.job.hex;
      upper <= rd.job.upper;
      idx   <= rd.job.top;
      pos   <= POS_W'(1);
    end else if (adv) begin
      if (!hex) begin
        rem <= rem_next;
      end
      idx <= idx - 1'b1;
      pos <= pos + 1'b1;
    end
    if (adv) begin
      char_code <= digit_char(dig, upper);
      position  <= pos;
      last      <= (idx == '0);
    end
  end

endmodule

### design/uint_to_ascii_digits.sv
// top level of the unsigned integer to ascii decimal / hex converter
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------
//   in      | in_valid, in_stall | value[31:0], opcode[1:0]
//   out     | out_valid, out_stall | char_code[6:0], position[3:0], last
//
// the digit sequencer handles a number of n digits (1..10) by first loading
// the job, then emitting one digit per cycle unless out_stall is set
// the front end classifies in the accept cycle and queues the job
// rst clears the queue, the sequencer state and the output valid
// out_stall holds the output register and halts the sequencer; in_stall rises
// once the job queue is full
module uint_to_ascii_digits #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [u2a_pkg::VALUE_W-1:0] value,
  input  logic [1:0]                  opcode,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [u2a_pkg::CHAR_W-1:0]  char_code,
  output logic [u2a_pkg::POS_W-1:0]   position,
  output logic                        last
);
  import u2a_pkg::*;

  q_wr_t wr;
  q_rd_t rd;
  logic  full;
  logic  pop;

  u2a_front u_front (
    .valid  (in_valid),
    .stall  (in_stall),
    .value  (value),
    .opcode (opcode),
    .full   (full),
    .wr     (wr)
  );

  u2a_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .full (full),
    .rd   (rd)
  );

  u2a_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd        (rd),
    .pop       (pop),
    .valid     (out_valid),
    .stall     (out_stall),
    .char_code (char_code),
    .position  (position),
    .last      (last)
  );

endmodule

### design/u2a_check.sv
// port-level checks for the converter, bound to the top level
module u2a_check (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [u2a_pkg::VALUE_W-1:0] value,
  input logic [1:0]                  opcode,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [u2a_pkg::CHAR_W-1:0]  char_code,
  input logic [u2a_pkg::POS_W-1:0]   position,
  input logic                        last
);
  import u2a_pkg::*;

  logic [POS_W-1:0] exp_pos;

  // position the next output beat should carry
  always_ff @(posedge clk) begin
    if (rst) begin
      exp_pos <= POS_W'(1);
    end else if (out_valid && !out_stall) begin
      exp_pos <= last ? POS_W'(1) : position + 1'b1;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(value) && $stable(opcode))
    else $error("stalled input beat changed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(position)
      && $stable(last))
    else $error("stalled output beat changed");

  a_char: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (char_code >= 7'h30 && char_code <= 7'h39)
      || (char_code >= 7'h41 && char_code <= 7'h46)
      || (char_code >= 7'h61 && char_code <= 7'h66))
    else $error("output is not a digit character");

  a_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> position == exp_pos)
    else $error("character position out of sequence");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && position == 4'd10 |-> last)
    else $error("more than ten characters in one number");

endmodule

bind uint_to_ascii_digits u2a_check u_check (.*);
